// ===== src/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII radix converter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package itoa_pkg;

    localparam int unsigned WORD_BITS_DEFAULT = 32;

    localparam int unsigned RADIX_FIELD_W = 8;
    localparam int unsigned RADIX_W       = 5;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned LEN_W         = 6;

    localparam logic [RADIX_FIELD_W-1:0] RADIX_MIN    = 8'd2;
    localparam logic [RADIX_FIELD_W-1:0] RADIX_MAX    = 8'd16;
    localparam logic [RADIX_FIELD_W-1:0] RADIX_SIGNED = 8'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    // 'a' minus ten, so that a digit of ten or more maps onto 'a'..'f'.
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 8'h57;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } itoa_state_t;

    typedef struct packed {
        logic start;
        logic resume;
    } div_cmd_t;

    typedef struct packed {
        logic                done;
        logic                quo_zero;
        logic [DIGIT_W-1:0]  digit;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN)
            return CHAR_ZERO + wide;
        else
            return CHAR_ALPHA_BASE + wide;
    endfunction

endpackage

`default_nettype wire

// ===== src/itoa_in_if.sv =====
// Input channel of the converter: one beat carries a word, a radix and a mode.
// Depends on itoa_pkg for the default word width and the radix field width.
`default_nettype none

interface itoa_in_if #(
    parameter int unsigned WORD_BITS = itoa_pkg::WORD_BITS_DEFAULT
);
    logic                                  valid;
    logic                                  ready;
    logic                                  mode;
    logic [WORD_BITS-1:0]                  value;
    logic [itoa_pkg::RADIX_FIELD_W-1:0]    radix;

    modport source (output valid, mode, value, radix, input ready);
    modport sink   (input valid, mode, value, radix, output ready);
endinterface

`default_nettype wire

// ===== src/itoa_out_if.sv =====
// Output channel of the converter: one beat carries one ASCII character.
// Depends on itoa_pkg for the field widths.
`default_nettype none

interface itoa_out_if;
    logic                            valid;
    logic                            ready;
    logic [itoa_pkg::CHAR_W-1:0]     char_code;
    logic                            last;
    logic                            invalid;
    logic [itoa_pkg::LEN_W-1:0]      length;

    modport source (output valid, char_code, last, invalid, length, input ready);
    modport sink   (input valid, char_code, last, invalid, length, output ready);
endinterface

`default_nettype wire

// ===== src/integer_to_ascii_radix.sv =====
// Integer to ASCII converter, radix 2 to 16; top level with the control sequencer.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_divider and itoa_digit_store.
//
// word_ch takes one beat per conversion: mode, value and radix. char_ch returns one
// beat per character, most significant digit first, with last on the final one and
// the total length on every beat. A radix outside 2..16 returns a single beat with
// invalid and last set and no character. A minus sign leads only for signed mode in
// radix 10 with a negative word.
// Each digit comes from the bit-serial divider, which produces one quotient bit per
// cycle; each character is then read from the digit store and loaded into the
// output register, after the minus sign when there is one. An invalid radix goes
// straight to loading its single invalid beat.
// One word is converted at a time. word_ch.ready rises again as soon as the final
// beat sits in the output register, so the next word can enter while it waits.
// A stalled receiver holds the output register and the sequencer waits with it.
// Reset clears the sequencer and the output valid; the store needs no clearing.
`default_nettype none

module integer_to_ascii_radix #(
    parameter int unsigned WORD_BITS = itoa_pkg::WORD_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    itoa_in_if.sink         word_ch,
    itoa_out_if.source      char_ch
);
    import itoa_pkg::*;

    localparam int unsigned AW    = $clog2(WORD_BITS);
    localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

    itoa_state_t state_reg;
    itoa_state_t state_next;

    logic                  neg_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [AW-1:0]         rd_ptr_reg;
    logic [LEN_W-1:0]      len_reg;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_last_reg;
    logic                  out_invalid_reg;
    logic [LEN_W-1:0]      out_len_reg;

    logic                  in_fire;
    logic                  radix_bad;
    logic                  is_neg;
    logic                  load_ok;
    logic [WORD_BITS-1:0]  dividend;
    logic [CNT_W-1:0]      count_plus;
    logic                  div_finish;

    div_cmd_t              div_cmd;
    div_stat_t             div_stat;

    logic                  st_we;
    logic                  st_re;
    logic [DIGIT_W-1:0]    st_rdata;

    logic                  ready_out;
    logic                  out_load;
    logic [CHAR_W-1:0]     char_sel;
    logic                  last_sel;
    logic                  invalid_sel;
    logic [LEN_W-1:0]      len_sel;

    assign in_fire    = word_ch.valid && word_ch.ready;
    assign radix_bad  = (word_ch.radix < RADIX_MIN) || (word_ch.radix > RADIX_MAX);
    assign is_neg     = word_ch.mode && (word_ch.radix == RADIX_SIGNED)
                        && word_ch.value[WORD_BITS-1];
    assign dividend   = is_neg ? (~word_ch.value + WORD_BITS'(1)) : word_ch.value;
    assign load_ok    = !out_valid_reg || char_ch.ready;
    assign count_plus = count_reg + CNT_W'(1);
    assign div_finish = (state_reg == ST_DIVIDE) && div_stat.done && div_stat.quo_zero;

    itoa_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (dividend),
        .radix    (radix_reg),
        .stat     (div_stat)
    );

    itoa_digit_store #(
        .DEPTH (WORD_BITS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (div_stat.digit),
        .re    (st_re),
        .raddr (rd_ptr_reg),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = radix_bad ? ST_BAD : ST_DIVIDE;
            end
            ST_BAD:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (div_finish)
                    state_next = neg_reg ? ST_SIGN : ST_READ;
            end
            ST_SIGN:
            begin
                if (load_ok)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                    state_next = (rd_ptr_reg == '0) ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready_out      = 1'b0;
        div_cmd.start  = 1'b0;
        div_cmd.resume = 1'b0;
        st_we          = 1'b0;
        st_re          = 1'b0;
        out_load       = 1'b0;
        char_sel       = CHAR_NONE;
        last_sel       = 1'b0;
        invalid_sel    = 1'b0;
        len_sel        = len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready_out     = 1'b1;
                div_cmd.start = word_ch.valid && !radix_bad;
            end
            ST_BAD:
            begin
                out_load    = load_ok;
                last_sel    = 1'b1;
                invalid_sel = 1'b1;
                len_sel     = '0;
            end
            ST_DIVIDE:
            begin
                st_we          = div_stat.done;
                div_cmd.resume = div_stat.done && !div_stat.quo_zero;
            end
            ST_SIGN:
            begin
                out_load = load_ok;
                char_sel = CHAR_MINUS;
            end
            ST_READ:
            begin
                st_re = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = load_ok;
                char_sel = digit_char(st_rdata);
                last_sel = (rd_ptr_reg == '0);
            end
            default:
            begin
                ready_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (char_ch.ready)
                out_valid_reg <= 1'b0;

            if (div_cmd.start)
                count_reg <= '0;
            else if (st_we)
                count_reg <= count_plus;

            // The most significant digit sits at the last index written.
            if (div_finish)
                rd_ptr_reg <= count_reg[AW-1:0];
            else if ((state_reg == ST_EMIT) && load_ok && (rd_ptr_reg != '0))
                rd_ptr_reg <= rd_ptr_reg - AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            neg_reg   <= is_neg;
            radix_reg <= word_ch.radix[RADIX_W-1:0];
        end
        if (div_finish)
            len_reg <= LEN_W'(count_plus) + LEN_W'(neg_reg);
        if (out_load)
        begin
            out_char_reg    <= char_sel;
            out_last_reg    <= last_sel;
            out_invalid_reg <= invalid_sel;
            out_len_reg     <= len_sel;
        end
    end

    assign word_ch.ready     = ready_out;
    assign char_ch.valid     = out_valid_reg;
    assign char_ch.char_code = out_char_reg;
    assign char_ch.last      = out_last_reg;
    assign char_ch.invalid   = out_invalid_reg;
    assign char_ch.length    = out_len_reg;

`ifndef ASSERT_OFF
    a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (char_ch.valid && char_ch.invalid) |-> (char_ch.last && char_ch.length == '0))
        else $error("invalid beat without last or with a nonzero length");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished a digit outside the divide phase");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (CNT_W'(rd_ptr_reg) < count_reg))
        else $error("digit read pointer beyond the digits found");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EMIT))
        else $error("store read not followed by a character load");
`endif

endmodule

`default_nettype wire

// ===== src/itoa_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder is one digit.
// Depends on itoa_pkg for the command and status structs.
`default_nettype none

module itoa_divider #(
    parameter int unsigned WORD_BITS = itoa_pkg::WORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itoa_pkg::div_cmd_t            cmd,
    input  logic [WORD_BITS-1:0]          dividend,
    input  logic [itoa_pkg::RADIX_W-1:0]  radix,
    output itoa_pkg::div_stat_t           stat
);
    import itoa_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] quo_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [RADIX_W-1:0]   trial;
    logic [RADIX_W-1:0]   diff;
    logic                 fits;
    logic                 cnt_last;
    logic                 launch;

    assign trial    = {rem_reg, quo_reg[WORD_BITS-1]};
    assign fits     = (trial >= radix);
    assign diff     = trial - radix;
    // The partial remainder always stays below the radix, so four bits hold it.
    assign rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    assign quo_next = {quo_reg[WORD_BITS-2:0], fits};
    assign cnt_last = (cnt_reg == CNT_W'(WORD_BITS - 1));
    assign launch   = cmd.start || cmd.resume;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cmd.resume)
        begin
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && cnt_last && !launch;
            if (launch)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_last)
                    busy_reg <= 1'b0;
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.quo_zero = (quo_reg == {WORD_BITS{1'b0}});
    assign stat.digit    = rem_reg;

endmodule

`default_nettype wire

// ===== src/itoa_digit_store.sv =====
// Digit store: one write port and one registered read port, four bits per entry.
// Depends on itoa_pkg for the digit width.
`default_nettype none

module itoa_digit_store #(
    parameter int unsigned DEPTH = itoa_pkg::WORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [itoa_pkg::DIGIT_W-1:0]  wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [itoa_pkg::DIGIT_W-1:0]  rdata
);
    import itoa_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== test/tb_integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_radix: random words, radixes and modes
// go in, and each returned character is checked against a predicted digit string.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if and the converter itself.

module tb_integer_to_ascii_radix;

    import itoa_pkg::*;

    localparam int unsigned WORD_BITS    = WORD_BITS_DEFAULT;
    localparam int          RANDOM_WORDS = 300;
    localparam int          CALM_WORDS   = 40;
    localparam int          DRAIN_CYCLES = 3 * (WORD_BITS + 3);

    typedef struct {
        bit                      mode;
        bit [WORD_BITS-1:0]      value;
        bit [RADIX_FIELD_W-1:0]  radix;
    } word_item_t;

    typedef struct {
        bit [CHAR_W-1:0] char_code;
        bit              last;
        bit              invalid;
        bit [LEN_W-1:0]  length;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    itoa_in_if #(.WORD_BITS(WORD_BITS)) word_ch ();
    itoa_out_if                         char_ch ();

    integer_to_ascii_radix #(.WORD_BITS(WORD_BITS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .word_ch (word_ch),
        .char_ch (char_ch)
    );

    word_item_t word_queue[$];
    char_beat_t expected_chars[$];
    word_item_t cur_word;

    int  send_gap;
    int  recv_gap;
    bit  calm;
    int  fail_count;
    int  words_converted;
    int  bad_radix_words;
    int  negative_words;
    int  chars_checked;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Works out the characters that one accepted word must produce.
    function automatic void predict_chars(input word_item_t w);
        bit [WORD_BITS-1:0] mag;
        bit [DIGIT_W-1:0]   digits[$];
        bit                 neg;
        bit [LEN_W-1:0]     total;
        char_beat_t         beat;
        words_converted++;
        if (w.radix < RADIX_MIN || w.radix > RADIX_MAX)
        begin
            bad_radix_words++;
            beat = '{char_code: CHAR_NONE, last: 1'b1, invalid: 1'b1, length: '0};
            expected_chars.push_back(beat);
            return;
        end
        neg = w.mode && (w.radix == RADIX_SIGNED) && w.value[WORD_BITS-1];
        mag = neg ? -w.value : w.value;
        do
        begin
            digits.push_front(DIGIT_W'(mag % w.radix));
            mag = mag / w.radix;
        end
        while (mag != 0);
        total = LEN_W'(digits.size()) + LEN_W'(neg);
        if (neg)
        begin
            negative_words++;
            beat = '{char_code: "-", last: 1'b0, invalid: 1'b0, length: total};
            expected_chars.push_back(beat);
        end
        foreach (digits[i])
        begin
            beat.char_code = (digits[i] < 10) ? CHAR_W'("0" + digits[i])
                                              : CHAR_W'("a" + digits[i] - 10);
            beat.last      = (i == digits.size() - 1);
            beat.invalid   = 1'b0;
            beat.length    = total;
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic void add_word(input bit mode, input bit [WORD_BITS-1:0] value,
                                     input bit [RADIX_FIELD_W-1:0] radix);
        word_item_t w;
        w.mode  = mode;
        w.value = value;
        w.radix = radix;
        word_queue.push_back(w);
    endfunction

    function automatic bit [WORD_BITS-1:0] random_value();
        case ($urandom_range(0, 4))
            0: return WORD_BITS'($urandom_range(0, 255));
            1: return WORD_BITS'($urandom >> $urandom_range(0, WORD_BITS - 1));
            2: return WORD_BITS'({1'b1, {(WORD_BITS-1){1'b0}}} + $urandom_range(0, 3) - 2);
            3: return WORD_BITS'(-$urandom_range(1, 1000));
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    function automatic bit [RADIX_FIELD_W-1:0] random_radix();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return RADIX_FIELD_W'($urandom_range(0, 1));
        else if (pick < 12)
            return RADIX_FIELD_W'($urandom_range(RADIX_MAX + 1, 255));
        else if (pick < 30)
            return RADIX_SIGNED;
        else
            return RADIX_FIELD_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Word driver: holds each beat until accepted, with bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_ch.valid <= 1'b0;
            word_ch.mode  <= 1'b0;
            word_ch.value <= '0;
            word_ch.radix <= '0;
            calm          <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (word_ch.valid && word_ch.ready)
                predict_chars(cur_word);
            if (!(word_ch.valid && !word_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    word_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 7) - 1;
                    word_ch.valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    cur_word = word_queue.pop_front();
                    word_ch.valid <= 1'b1;
                    word_ch.mode  <= cur_word.mode;
                    word_ch.value <= cur_word.value;
                    word_ch.radix <= cur_word.radix;
                    calm <= (word_queue.size() <= CALM_WORDS);
                end
                else
                begin
                    word_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Character monitor: checks every accepted beat and stalls in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t exp_beat;
        if (!rst_n)
        begin
            char_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character beat: char_code %0h", char_ch.char_code);
                    fail_count++;
                end
                else
                begin
                    exp_beat = expected_chars.pop_front();
                    check_field("char_code", 32'(exp_beat.char_code),
                                32'(char_ch.char_code));
                    check_field("last", 32'(exp_beat.last), 32'(char_ch.last));
                    check_field("invalid", 32'(exp_beat.invalid), 32'(char_ch.invalid));
                    check_field("length", 32'(exp_beat.length), 32'(char_ch.length));
                    chars_checked++;
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                char_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(1, 7) - 1;
                char_ch.ready <= 1'b0;
            end
            else
            begin
                char_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // Directed words: zero, full-width values, the most negative word,
        // the sign rule in and out of radix 10, and out-of-range radixes.
        add_word(1'b0, 32'h0000_0000, RADIX_SIGNED);
        add_word(1'b0, 32'h0000_0000, RADIX_MIN);
        add_word(1'b1, 32'h0000_0000, RADIX_MAX);
        add_word(1'b0, 32'hFFFF_FFFF, RADIX_MIN);
        add_word(1'b0, 32'hFFFF_FFFF, RADIX_MAX);
        add_word(1'b0, 32'hFFFF_FFFF, RADIX_SIGNED);
        add_word(1'b1, 32'hFFFF_FFFF, RADIX_SIGNED);
        add_word(1'b1, 32'h8000_0000, RADIX_SIGNED);
        add_word(1'b0, 32'h8000_0000, RADIX_SIGNED);
        add_word(1'b1, 32'h7FFF_FFFF, RADIX_SIGNED);
        add_word(1'b1, 32'h8000_0000, RADIX_MAX);
        add_word(1'b1, 32'hFFFF_FFFF, RADIX_MIN);
        add_word(1'b0, 32'h0000_0000, 8'd0);
        add_word(1'b1, 32'h0000_007B, 8'd1);
        add_word(1'b0, 32'h0000_0005, RADIX_MAX + 8'd1);
        add_word(1'b1, 32'hFFFF_FFFF, 8'd255);
        add_word(1'b0, 32'h0000_0000, 8'd128);
        add_word(1'b0, 32'h1234_5678, 8'd3);
        add_word(1'b0, 32'hDEAD_BEEF, RADIX_MAX);
        add_word(1'b1, 32'hFFFF_FFF6, RADIX_SIGNED);
        add_word(1'b0, 32'h0000_0001, 8'd15);
        add_word(1'b1, 32'hAAAA_AAAA, 8'd7);
        add_word(1'b0, 32'h0000_000F, RADIX_MAX);
        add_word(1'b0, 32'h0000_0010, RADIX_MAX);
        add_word(1'b1, 32'h5555_5555, 8'd9);

        for (int n = 0; n < RANDOM_WORDS; n++)
            add_word(1'($urandom_range(0, 1)), random_value(), random_radix());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (word_queue.size() != 0 || word_ch.valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d words: %0d with a bad radix, %0d shown with a minus sign.",
                 words_converted, bad_radix_words, negative_words);
        $display("Checked %0d character beats under random sender gaps and receiver stalls.",
                 chars_checked);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== integer_to_ascii_radix.f =====
src/itoa_pkg.sv
src/itoa_in_if.sv
src/itoa_out_if.sv
src/itoa_divider.sv
src/itoa_digit_store.sv
src/integer_to_ascii_radix.sv
test/tb_integer_to_ascii_radix.sv
